// File: design/rx_reorder_bitmap_tracker_assert.svh
// Assertion macros for the receive reorder tracker.
`ifndef RX_REORDER_BITMAP_TRACKER_ASSERT_SVH
`define RX_REORDER_BITMAP_TRACKER_ASSERT_SVH

// Check a condition on every clock edge outside reset.
`define RRBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a trigger leads to a consequence in the next cycle.
`define RRBT_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// File: design/rrbt_pkg.sv
package rrbt_pkg;

  localparam int unsigned DW             = 32;
  localparam int unsigned WIN_W          = 7;
  localparam int unsigned NUM_FLOWS_DEF  = 16;
  localparam int unsigned MAX_WINDOW_DEF = 64;

  // Input beat kinds carried in tuser.
  typedef enum logic {
    CMD_DATA  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_e;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] dividend;
    logic [DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [DW-1:0] quo;
    logic [DW-1:0] rem;
  } div_rsp_t;

endpackage

// File: design/rx_reorder_bitmap_tracker.sv
// Receive-side reorder tracker: one expected sequence and one circular
// arrival bitmap per flow.
// Input stream (s_axis): one beat per packet or per clear-flow command;
// tuser selects the command. Output stream (m_axis): one beat per data
// packet carrying ack, base PSN, rotated bitmap and flags. A clear-flow
// command is done in the accept cycle and produces no output beat.
// Configuration: cfg_we_i writes the window size (clamped to 1..MAX_WINDOW);
// a change of size clears every bitmap. Write only while the block is idle.
// Arithmetic: all divisions run through one shared 32-step divider. A
// stale or ahead-of-sequence packet takes four divisions plus a bitmap
// rotation over the window; an in-order packet adds two divisions and a
// drain that clears each buffered bit of the run in turn. One packet is
// worked at a time. The result sits in an output register; the next
// packet is accepted while it waits, but a finished packet holds in its
// last step until the receiver takes the previous beat. Reset clears
// every flow and sets the window to MAX_WINDOW.
module rx_reorder_bitmap_tracker
  import rrbt_pkg::*;
#(
  parameter int unsigned NUM_FLOWS  = NUM_FLOWS_DEF,
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // [3:0] flow_index, [35:4] seq_num, [67:36] payload_len, [99:68] pkt_unit
  input  logic [103:0]       s_axis_tdata_i,
  // [0] cmd
  input  logic               s_axis_tuser_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // [31:0] ack_value, [63:32] base_psn, [127:64] rotated_bits, [128] gap_flag
  output logic [135:0]       m_axis_tdata_o,
  // [0] send_ctrl, [1] nack_flag, [2] overflow_drop
  output logic [2:0]         m_axis_tuser_o,
  input  logic               cfg_we_i,
  input  logic [WIN_W-1:0]   cfg_wdata_i
);

  // Only 16 flow codes can arrive, so at most 16 flows are stored.
  localparam int unsigned NF = (NUM_FLOWS < 16) ? NUM_FLOWS : 16;
  localparam int unsigned FW = (NF > 1) ? $clog2(NF) : 1;
  localparam int unsigned PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DIV_PSN  = 4'd1;
  localparam logic [3:0] S_DIV_POS0 = 4'd2;
  localparam logic [3:0] S_UPD      = 4'd3;
  localparam logic [3:0] S_DIV_E1   = 4'd4;
  localparam logic [3:0] S_DIV_P1   = 4'd5;
  localparam logic [3:0] S_DRAIN    = 4'd6;
  localparam logic [3:0] S_DIV_BASE = 4'd7;
  localparam logic [3:0] S_CHK      = 4'd8;
  localparam logic [3:0] S_DIV_ROT  = 4'd9;
  localparam logic [3:0] S_ROT      = 4'd10;
  localparam logic [3:0] S_FIN      = 4'd11;

  // Per-flow state
  logic [DW-1:0]         exp_mem_q  [NF];
  logic [MAX_WINDOW-1:0] bits_mem_q [NF];
  logic [WIN_W-1:0]      win_q;

  // Sequencer and working registers
  logic [3:0]            state_q, state_d;
  logic [FW-1:0]         flow_q, flow_d;
  logic [DW-1:0]         seq_q, seq_d;
  logic [DW-1:0]         len_q, len_d;
  logic [DW-1:0]         step_q, step_d;
  logic [DW-1:0]         psn_q, psn_d;
  logic [DW-1:0]         exp_q, exp_d;
  logic [DW-1:0]         base_q, base_d;
  logic [MAX_WINDOW-1:0] bits_q, bits_d;
  logic [MAX_WINDOW-1:0] rot_q, rot_d;
  logic [PW-1:0]         pos0_q, pos0_d;
  logic [PW-1:0]         pos_q, pos_d;
  logic [WIN_W-1:0]      icnt_q, icnt_d;
  logic                  gt_q, gt_d;
  logic                  nack_q, nack_d;

  // Output register
  logic                  out_vld_q, out_vld_d;
  logic [135:0]          out_data_q, out_data_d;
  logic [2:0]            out_user_q, out_user_d;

  logic [3:0]            in_flow;
  logic [DW-1:0]         in_seq, in_len, in_unit;
  logic [FW-1:0]         in_flow_sel;
  logic                  in_fire, clr_fire, wb_en;
  logic [WIN_W-1:0]      cfg_win;
  logic [PW-1:0]         pos_next;
  div_req_t              div_req;
  div_rsp_t              div_rsp;

  assign in_flow = s_axis_tdata_i[3:0];
  assign in_seq  = s_axis_tdata_i[35:4];
  assign in_len  = s_axis_tdata_i[67:36];
  assign in_unit = s_axis_tdata_i[99:68];

  // Fold the flow code onto the stored flows.
  always_comb begin
    in_flow_sel = '0;
    for (int k = 0; k < 16; k++) begin
      if (in_flow == 4'(k)) in_flow_sel = FW'(k % NF);
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign clr_fire = in_fire && (s_axis_tuser_i == CMD_CLEAR);

  // Clamp the window write to 1..MAX_WINDOW.
  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_win = WIN_W'(1);
    end else if (cfg_wdata_i > WIN_W'(MAX_WINDOW)) begin
      cfg_win = WIN_W'(MAX_WINDOW);
    end else begin
      cfg_win = cfg_wdata_i;
    end
  end

  // Advance a bitmap position, wrapping at the window size.
  assign pos_next = ((WIN_W'(pos_q) + WIN_W'(1)) == win_q) ? '0 : pos_q + PW'(1);

  // Pick operands for the shared divider from the sequencer state.
  always_comb begin
    div_req.dividend = exp_q;
    div_req.divisor  = step_q;
    case (state_q)
      S_DIV_PSN: begin
        div_req.dividend = seq_q;
        div_req.divisor  = step_q;
      end
      S_DIV_POS0: begin
        div_req.dividend = psn_q;
        div_req.divisor  = DW'(win_q);
      end
      S_DIV_P1, S_DIV_ROT: begin
        div_req.dividend = base_q;
        div_req.divisor  = DW'(win_q);
      end
      default: begin
        div_req.dividend = exp_q;
        div_req.divisor  = step_q;
      end
    endcase
    div_req.start = ((state_q == S_DIV_PSN) || (state_q == S_DIV_POS0) ||
                     (state_q == S_DIV_E1) || (state_q == S_DIV_P1) ||
                     (state_q == S_DIV_BASE) || (state_q == S_DIV_ROT)) &&
                    !div_rsp.busy && !div_rsp.done;
  end

  rrbt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d    = state_q;
    flow_d     = flow_q;
    seq_d      = seq_q;
    len_d      = len_q;
    step_d     = step_q;
    psn_d      = psn_q;
    exp_d      = exp_q;
    base_d     = base_q;
    bits_d     = bits_q;
    rot_d      = rot_q;
    pos0_d     = pos0_q;
    pos_d      = pos_q;
    icnt_d     = icnt_q;
    gt_d       = gt_q;
    nack_d     = nack_q;
    out_vld_d  = out_vld_q && !m_axis_tready_i;
    out_data_d = out_data_q;
    out_user_d = out_user_q;
    wb_en      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire && (s_axis_tuser_i == CMD_DATA)) begin
          flow_d = in_flow_sel;
          seq_d  = in_seq;
          len_d  = in_len;
          if (in_unit != '0) begin
            step_d = in_unit;
          end else if (in_len != '0) begin
            step_d = in_len;
          end else begin
            step_d = DW'(1);
          end
          exp_d   = exp_mem_q[in_flow_sel];
          bits_d  = bits_mem_q[in_flow_sel];
          nack_d  = 1'b0;
          state_d = S_DIV_PSN;
        end
      end
      S_DIV_PSN: begin
        if (div_rsp.done) begin
          psn_d   = div_rsp.quo;
          state_d = S_DIV_POS0;
        end
      end
      S_DIV_POS0: begin
        if (div_rsp.done) begin
          pos0_d  = div_rsp.rem[PW-1:0];
          gt_d    = seq_q > exp_q;
          state_d = (seq_q == exp_q) ? S_UPD : S_DIV_BASE;
        end
      end
      S_UPD: begin
        // In-order data: drop its own bit and move past its payload.
        bits_d[pos0_q] = 1'b0;
        exp_d   = exp_q + len_q;
        state_d = S_DIV_E1;
      end
      S_DIV_E1: begin
        if (div_rsp.done) begin
          base_d  = div_rsp.quo;
          state_d = S_DIV_P1;
        end
      end
      S_DIV_P1: begin
        if (div_rsp.done) begin
          pos_d   = div_rsp.rem[PW-1:0];
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // Consume one buffered packet per cycle while the run continues.
        if (bits_q[pos_q]) begin
          bits_d[pos_q] = 1'b0;
          exp_d = exp_q + step_q;
          pos_d = pos_next;
        end else begin
          state_d = S_DIV_BASE;
        end
      end
      S_DIV_BASE: begin
        if (div_rsp.done) begin
          base_d  = div_rsp.quo;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (gt_q) begin
          if ({1'b0, psn_q} >= ({1'b0, base_q} + (DW+1)'(win_q))) begin
            nack_d = 1'b1;
          end else begin
            bits_d[pos0_q] = 1'b1;
          end
        end
        state_d = S_DIV_ROT;
      end
      S_DIV_ROT: begin
        if (div_rsp.done) begin
          pos_d   = div_rsp.rem[PW-1:0];
          icnt_d  = '0;
          rot_d   = '0;
          state_d = S_ROT;
        end
      end
      S_ROT: begin
        rot_d[icnt_q[PW-1:0]] = bits_q[pos_q];
        pos_d  = pos_next;
        icnt_d = icnt_q + WIN_W'(1);
        if ((icnt_q + WIN_W'(1)) == win_q) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // Hold here until the output register is free.
        wb_en = 1'b1;
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d  = 1'b1;
          out_data_d = {7'd0, |bits_q, 64'(rot_q), base_q, exp_q};
          out_user_d = {nack_q, nack_q, 1'b1};
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      win_q     <= WIN_W'(MAX_WINDOW);
      for (int f = 0; f < NF; f++) begin
        exp_mem_q[f]  <= '0;
        bits_mem_q[f] <= '0;
      end
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i && (cfg_win != win_q)) begin
        win_q <= cfg_win;
        for (int f = 0; f < NF; f++) begin
          bits_mem_q[f] <= '0;
        end
      end
      if (clr_fire) begin
        exp_mem_q[in_flow_sel]  <= '0;
        bits_mem_q[in_flow_sel] <= '0;
      end
      if (wb_en) begin
        exp_mem_q[flow_q]  <= exp_q;
        bits_mem_q[flow_q] <= bits_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    flow_q     <= flow_d;
    seq_q      <= seq_d;
    len_q      <= len_d;
    step_q     <= step_d;
    psn_q      <= psn_d;
    exp_q      <= exp_d;
    base_q     <= base_d;
    bits_q     <= bits_d;
    rot_q      <= rot_d;
    pos0_q     <= pos0_d;
    pos_q      <= pos_d;
    icnt_q     <= icnt_d;
    gt_q       <= gt_d;
    nack_q     <= nack_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  `include "rx_reorder_bitmap_tracker_assert.svh"

  `RRBT_ASSERT(a_win_range,
    (win_q != '0) && (win_q <= WIN_W'(MAX_WINDOW)), "window size out of range")
  `RRBT_ASSERT(a_div_idle_start, !div_req.start || !div_rsp.busy, "divider started while busy")
  `RRBT_ASSERT(a_pos_in_window,
    !((state_q == S_DRAIN) || (state_q == S_ROT)) || (WIN_W'(pos_q) < win_q),
    "bitmap position beyond window")
  `RRBT_ASSERT_NEXT(a_fin_loads, (state_q == S_FIN) && !out_vld_q,
    out_vld_q && (state_q == S_IDLE), "finished packet not loaded")

endmodule

// File: design/rrbt_div.sv
module rrbt_div
  import rrbt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [DW-1:0] den_q, den_d;
  logic [4:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [DW:0]   trial;

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign trial = {rem_q, quo_q[DW-1]} - {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (busy_q) begin
      if (!trial[DW]) begin
        rem_d = trial[DW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DW-2:0], quo_q[DW-1]};
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      den_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rrbt_pkg::*;

  localparam int unsigned FLOWS     = 16;
  localparam int unsigned WIN_MAX   = 64;
  localparam int unsigned LIMIT_CYC = 1_500_000;
  localparam int unsigned LAT_CYC   = 400;
  localparam int unsigned ACK_DEPTH = 16;

  typedef struct packed {
    logic        gap;
    logic [63:0] rot;
    logic [31:0] base;
    logic [31:0] ack;
    logic        drop;
    logic        nack;
    logic        ctrl;
  } ack_rec_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           s_axis_tvalid_i = 1'b0;
  logic           s_axis_tready_o;
  logic [103:0]   s_axis_tdata_i = '0;
  logic           s_axis_tuser_i = 1'b0;
  logic           m_axis_tvalid_o;
  logic           m_axis_tready_i = 1'b0;
  logic [135:0]   m_axis_tdata_o;
  logic [2:0]     m_axis_tuser_o;
  logic           cfg_we_i = 1'b0;
  logic [WIN_W-1:0] cfg_wdata_i = '0;

  rx_reorder_bitmap_tracker dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o,
    .cfg_we_i, .cfg_wdata_i
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow flow state kept by the predictor.
  logic [31:0] exp_seq [FLOWS];
  logic [63:0] arr_bits [FLOWS];
  int unsigned win_len;

  // Expected beats in order; written on accept, read by the checker.
  ack_rec_t ack_fifo [ACK_DEPTH];
  int unsigned wr_cnt = 0;
  int unsigned rd_cnt = 0;
  int unsigned err_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_off;
  longint unsigned cyc = 0;

  // Return the entries of bits starting at base, wrapped at the window length.
  function automatic logic [63:0] rotate_bits(logic [63:0] bits, logic [31:0] base);
    logic [63:0] r;
    int unsigned pos;
    r = '0;
    pos = base % win_len;
    for (int unsigned i = 0; i < win_len; i++) begin
      r[i] = bits[pos];
      pos = (pos + 1 == win_len) ? 0 : pos + 1;
    end
    return r;
  endfunction

  // Apply one beat to the shadow state and, for a data beat, queue the expected ack beat.
  function automatic void track_packet(cmd_e cmd, logic [3:0] flow, logic [31:0] seq,
                                       logic [31:0] len, logic [31:0] unit);
    logic [31:0] stp;
    logic [31:0] ex;
    logic [63:0] bits;
    logic [63:0] psn;
    logic [63:0] lim;
    int unsigned pos;
    ack_rec_t r;
    if (cmd == CMD_CLEAR) begin
      exp_seq[flow] = '0;
      arr_bits[flow] = '0;
      return;
    end
    stp = (unit != 0) ? unit : ((len != 0) ? len : 32'd1);
    ex = exp_seq[flow];
    bits = arr_bits[flow] & ((win_len >= 64) ? {64{1'b1}} : ((64'd1 << win_len) - 1));
    r = '0;
    if (seq == ex) begin
      bits[(seq / stp) % win_len] = 1'b0;
      ex = ex + len;
      pos = (ex / stp) % win_len;
      while (bits[pos]) begin
        bits[pos] = 1'b0;
        ex = ex + stp;
        pos = (pos + 1 == win_len) ? 0 : pos + 1;
      end
    end else if (seq > ex) begin
      psn = 64'(seq / stp);
      lim = 64'(ex / stp) + 64'(win_len);
      if (psn >= lim) r.nack = 1'b1;
      else bits[psn % win_len] = 1'b1;
    end
    exp_seq[flow] = ex;
    arr_bits[flow] = bits;
    r.ctrl = 1'b1;
    r.drop = r.nack;
    r.ack = ex;
    r.base = ex / stp;
    r.rot = rotate_bits(bits, r.base);
    r.gap = (bits != 0);
    ack_fifo[wr_cnt % ACK_DEPTH] = r;
    wr_cnt++;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cyc);
    err_cnt++;
  endtask

  // Send one beat; idle at random first. Valid stays up on return so a
  // following beat can go out back to back; callers drop it when pausing.
  task automatic send_beat(cmd_e cmd, logic [3:0] flow, logic [31:0] seq,
                           logic [31:0] len, logic [31:0] unit);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= cmd;
    s_axis_tdata_i <= {4'd0, unit, len, seq, flow};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    track_packet(cmd, flow, seq, len, unit);
  endtask

  task automatic drain_wait();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (wr_cnt != rd_cnt) @(posedge clk_i);
    repeat (LAT_CYC) @(posedge clk_i);
  endtask

  // Write the window length while idle; mirror the clamp and clear.
  task automatic write_window(logic [WIN_W-1:0] val);
    int unsigned w;
    drain_wait();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    w = (val < 1) ? 1 : ((val > WIN_MAX) ? WIN_MAX : val);
    if (w != win_len) begin
      win_len = w;
      foreach (arr_bits[f]) arr_bits[f] = '0;
    end
  endtask

  // Random beat: mostly packets near the expected sequence of a flow.
  task automatic send_random();
    logic [3:0] flow;
    logic [31:0] unit;
    logic [31:0] seq;
    logic [31:0] len;
    int unsigned k;
    flow = 4'($urandom_range(3));
    if ($urandom_range(9) == 0) flow = 4'($urandom);
    k = $urandom_range(99);
    unit = (k < 10) ? 32'd0 : ((k < 15) ? $urandom : 32'd100);
    len = (unit == 0) ? $urandom_range(200) : unit;
    if ($urandom_range(19) == 0) len = $urandom;
    k = $urandom_range(99);
    if (k < 3) begin
      send_beat(CMD_CLEAR, flow, $urandom, $urandom, $urandom);
      return;
    end else if (k < 40) seq = exp_seq[flow];
    else if (k < 80) seq = exp_seq[flow] + 100 * $urandom_range(win_len + 1);
    else if (k < 90) seq = exp_seq[flow] - $urandom_range(300);
    else seq = $urandom;
    send_beat(CMD_DATA, flow, seq, len, unit);
  endtask

  task automatic test_directed();
    send_beat(CMD_DATA, 4'd0, 32'd0, 32'd100, 32'd100);
    send_beat(CMD_DATA, 4'd0, 32'd300, 32'd100, 32'd100);
    send_beat(CMD_DATA, 4'd0, 32'd200, 32'd100, 32'd100);
    send_beat(CMD_DATA, 4'd0, 32'd100, 32'd100, 32'd100);
    send_beat(CMD_DATA, 4'd0, 32'd50, 32'd100, 32'd100);
    send_beat(CMD_DATA, 4'd0, 32'd100000, 32'd100, 32'd100);
    send_beat(CMD_DATA, 4'd15, 32'd0, 32'd0, 32'd0);
    send_beat(CMD_DATA, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_beat(CMD_DATA, 4'd15, 32'd1, 32'hFFFF_FFFF, 32'd0);
    send_beat(CMD_DATA, 4'd15, 32'hFFFF_FFFF, 32'd5, 32'd1);
    send_beat(CMD_DATA, 4'd15, 32'hFFFF_FFFF, 32'd5, 32'd1);
    send_beat(CMD_DATA, 4'd15, 32'h0000_0004, 32'd3, 32'hFFFF_FFFF);
    send_beat(CMD_CLEAR, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(CMD_DATA, 4'd0, 32'd0, 32'd7, 32'd0);
    send_beat(CMD_CLEAR, 4'd15, 32'd0, 32'd0, 32'd0);
    send_beat(CMD_DATA, 4'd15, 32'd64, 32'd1, 32'd1);
    send_beat(CMD_DATA, 4'd15, 32'd63, 32'd1, 32'd1);
  endtask

  task automatic test_window_sizes();
    write_window(7'd0);
    repeat (20) send_random();
    write_window(7'd127);
    write_window(7'd64);
    repeat (20) send_random();
    write_window(7'd3);
    repeat (30) send_random();
  endtask

  // Receiver holds off while the sender keeps offering beats.
  task automatic test_backpressure();
    hold_off = 600;
    repeat (10) send_random();
    drain_wait();
    repeat (10) send_random();
  endtask

  task automatic test_random();
    send_idle_pct = 33;
    recv_idle_pct = 86;
    write_window(7'd8);
    repeat (300) send_random();
    send_idle_pct = 86;
    recv_idle_pct = 33;
    write_window(7'd64);
    repeat (300) send_random();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_window(7'd17);
    repeat (350) send_random();
  endtask

  // Receiver side: random stalls plus the long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_off != 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every output beat against the oldest prediction.
  always @(posedge clk_i) begin
    ack_rec_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (wr_cnt == rd_cnt) begin
        report_mismatch("unexpected beat", m_axis_tdata_o[63:0], '0);
      end else begin
        want = ack_fifo[rd_cnt % ACK_DEPTH];
        rd_cnt++;
        if (m_axis_tuser_o[0] !== want.ctrl)
          report_mismatch("send_ctrl", 64'(m_axis_tuser_o[0]), 64'(want.ctrl));
        if (m_axis_tuser_o[1] !== want.nack)
          report_mismatch("nack_flag", 64'(m_axis_tuser_o[1]), 64'(want.nack));
        if (m_axis_tuser_o[2] !== want.drop)
          report_mismatch("overflow_drop", 64'(m_axis_tuser_o[2]), 64'(want.drop));
        if (m_axis_tdata_o[31:0] !== want.ack)
          report_mismatch("ack_value", 64'(m_axis_tdata_o[31:0]), 64'(want.ack));
        if (m_axis_tdata_o[63:32] !== want.base)
          report_mismatch("base_psn", 64'(m_axis_tdata_o[63:32]), 64'(want.base));
        if (m_axis_tdata_o[127:64] !== want.rot)
          report_mismatch("rotated_bits", m_axis_tdata_o[127:64], want.rot);
        if (m_axis_tdata_o[128] !== want.gap)
          report_mismatch("gap_flag", 64'(m_axis_tdata_o[128]), 64'(want.gap));
      end
    end
  end

  // Watchdog on total cycles.
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT_CYC) begin
      $display("FAIL rx_reorder_bitmap_tracker");
      $finish;
    end
  end

  initial begin
    err_cnt = 0;
    hold_off = 0;
    send_idle_pct = 20;
    recv_idle_pct = 20;
    win_len = WIN_MAX;
    foreach (exp_seq[f]) begin
      exp_seq[f] = '0;
      arr_bits[f] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_window_sizes();
    test_backpressure();
    test_random();
    drain_wait();
    if (err_cnt == 0 && wr_cnt == rd_cnt) begin
      $display("PASS rx_reorder_bitmap_tracker");
    end else begin
      $display("FAIL rx_reorder_bitmap_tracker");
    end
    $finish;
  end

endmodule
